/* design/sll_pkg.sv */
// sll_pkg: shared types and codes for the sequential list engine.
// No dependencies; imported by the cell, the core and the checker.
`default_nettype none

package sll_pkg;

    localparam int VALUE_W = 32;
    localparam int FUNC_W  = 4;
    localparam int STAT_W  = 2;

    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 4'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 4'd1;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 4'd2;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 4'd3;
    localparam logic [FUNC_W-1:0] FN_INSERT     = 4'd4;
    localparam logic [FUNC_W-1:0] FN_ERASE      = 4'd5;
    localparam logic [FUNC_W-1:0] FN_FIND       = 4'd6;
    localparam logic [FUNC_W-1:0] FN_MODIFY     = 4'd7;
    localparam logic [FUNC_W-1:0] FN_CLEAR      = 4'd8;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ERASE,
        CELL_WRITE,
        CELL_MATCH,
        CELL_SCAN
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [VALUE_W-1:0] value;
    } cell_ctrl_t;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } sll_state_t;

endpackage

`default_nettype wire

/* design/sll_cell.sv */
// sll_cell: one list slot; holds an element and a match flag, trades with neighbors.
// Depends on sll_pkg.
`default_nettype none

module sll_cell
    import sll_pkg::*;
#(
    parameter int IDX = 0,
    parameter int IW  = 6,
    parameter int PW  = 7
)
(
    input  wire                        clk,
    input  wire cell_ctrl_t            ctrl,
    input  wire        [IW-1:0]        idx,
    input  wire        [PW-1:0]        count,
    input  wire signed [VALUE_W-1:0]   left_data,
    input  wire signed [VALUE_W-1:0]   right_data,
    input  wire                        match_in,
    output logic signed [VALUE_W-1:0]  data,
    output logic                       match
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);
    localparam logic [PW-1:0] MY_POS = PW'(IDX);

    logic signed [VALUE_W-1:0] data_reg, data_next;
    logic                      match_reg, match_next;

    always_comb
    begin
        data_next  = data_reg;
        match_next = match_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (MY_IDX > idx)
                    data_next = left_data;
                else if (MY_IDX == idx)
                    data_next = ctrl.value;
            end
            CELL_ERASE:
            begin
                if (MY_IDX >= idx)
                    data_next = right_data;
            end
            CELL_WRITE:
            begin
                if (MY_IDX == idx)
                    data_next = ctrl.value;
            end
            CELL_MATCH: match_next = (data_reg == ctrl.value) && (MY_POS < count);
            CELL_SCAN:  match_next = match_in;
            default:    ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

/* design/sequential_list_engine_core.sv */
// sequential_list_engine_core: ordered list of signed words in a row of cells.
// Depends on sll_pkg and sll_cell.
//
// One request at a time. Push, pop, insert, erase, modify and clear need no scan:
// every cell shifts, loads or holds in parallel. Find on a non-empty list scans:
// all cells compare at once, then the match flags shift toward the head
// one cell per cycle until the first match or the end of the list is seen.
// A result sits in an output register; the next request is taken in the cycle
// the result leaves or once it has left.
`default_nettype none

module sequential_list_engine_core
    import sll_pkg::*;
#(
    parameter  int CAPACITY = 64,
    localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int PW  = $clog2(CAPACITY + 1),
    localparam int FW  = PW + 1,
    localparam int IDW = ((PW + VALUE_W + 7) / 8) * 8,
    localparam int ODW = ((STAT_W + FW + PW + 7) / 8) * 8
)
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              s_tvalid,
    output logic             s_tready,
    input  wire  [IDW-1:0]   s_tdata,   // position, value
    input  wire  [FUNC_W-1:0] s_tuser,  // func
    output logic             m_tvalid,
    input  wire              m_tready,
    output logic [ODW-1:0]   m_tdata    // status, found_position, item_count
);

    logic [PW-1:0]             pos;
    logic signed [VALUE_W-1:0] val;
    logic [FUNC_W-1:0]         func;

    assign pos  = s_tdata[PW-1:0];
    assign val  = s_tdata[PW+VALUE_W-1:PW];
    assign func = s_tuser;

    sll_state_t state_reg, state_next;
    logic [PW-1:0] count_reg, count_next;
    logic [IW-1:0] k_reg, k_next;

    logic              m_tvalid_reg;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [FW-1:0]     found_reg, found_next;
    logic [PW-1:0]     outcnt_reg;

    cell_ctrl_t    ctrl;
    logic [IW-1:0] cell_idx;
    logic          load_out;

    logic signed [VALUE_W-1:0] cell_data  [CAPACITY];
    logic                      cell_match [CAPACITY];

    logic accept, out_free, empty, full;
    logic [PW:0]   pos_ext, cnt_ext, cnt_p1;
    logic [PW-1:0] pos_m1, k_p1;
    logic          head, scan_done;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == PW'(CAPACITY));
    assign pos_ext  = {1'b0, pos};
    assign cnt_ext  = {1'b0, count_reg};
    assign cnt_p1   = cnt_ext + 1'b1;
    assign pos_m1   = pos - 1'b1;
    assign k_p1     = PW'(k_reg) + 1'b1;
    assign head     = cell_match[0];
    assign scan_done = head || (k_p1 >= count_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && func == FN_FIND && !empty)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_done && out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl.op     = CELL_HOLD;
        ctrl.value  = val;
        cell_idx    = '0;
        count_next  = count_reg;
        k_next      = k_reg;
        load_out    = 1'b0;
        status_next = ST_OK;
        found_next  = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    load_out = 1'b1;
                    case (func)
                        FN_PUSH_BACK, FN_PUSH_FRONT:
                        begin
                            if (full)
                                status_next = ST_FULL;
                            else
                            begin
                                ctrl.op    = CELL_INSERT;
                                cell_idx   = (func == FN_PUSH_BACK) ? count_reg[IW-1:0] : '0;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        FN_POP_BACK, FN_POP_FRONT:
                        begin
                            if (empty)
                                status_next = ST_EMPTY;
                            else
                            begin
                                if (func == FN_POP_FRONT)
                                    ctrl.op = CELL_ERASE;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        FN_INSERT:
                        begin
                            if (full)
                                status_next = ST_FULL;
                            else if (pos == '0 || pos_ext > cnt_p1)
                                status_next = ST_BADPOS;
                            else
                            begin
                                ctrl.op    = CELL_INSERT;
                                cell_idx   = pos_m1[IW-1:0];
                                count_next = count_reg + 1'b1;
                            end
                        end
                        FN_ERASE, FN_MODIFY:
                        begin
                            if (empty)
                                status_next = ST_EMPTY;
                            else if (pos == '0 || pos > count_reg)
                                status_next = ST_BADPOS;
                            else
                            begin
                                cell_idx = pos_m1[IW-1:0];
                                if (func == FN_ERASE)
                                begin
                                    ctrl.op    = CELL_ERASE;
                                    count_next = count_reg - 1'b1;
                                end
                                else
                                    ctrl.op = CELL_WRITE;
                            end
                        end
                        FN_FIND:
                        begin
                            if (empty)
                                found_next = '1;
                            else
                            begin
                                ctrl.op  = CELL_MATCH;
                                k_next   = '0;
                                load_out = 1'b0;
                            end
                        end
                        FN_CLEAR: count_next = '0;
                        default:  ;
                    endcase
                end
            end
            S_SCAN:
            begin
                found_next = head ? {1'b0, k_p1} : '1;
                if (scan_done)
                    load_out = out_free;
                else
                begin
                    ctrl.op = CELL_SCAN;
                    k_next  = k_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            k_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            if (load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
            outcnt_reg <= count_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = ODW'({outcnt_reg, found_reg, status_reg});

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [VALUE_W-1:0] left_d, right_d;
            logic                      match_up;
            if (gi == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_d  = '0;
                assign match_up = 1'b0;
            end
            else
            begin : g_mid_r
                assign right_d  = cell_data[gi+1];
                assign match_up = cell_match[gi+1];
            end
            sll_cell #(
                .IDX (gi),
                .IW  (IW),
                .PW  (PW)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .idx        (cell_idx),
                .count      (count_reg),
                .left_data  (left_d),
                .right_data (right_d),
                .match_in   (match_up),
                .data       (cell_data[gi]),
                .match      (cell_match[gi])
            );
        end
    endgenerate

endmodule

`default_nettype wire

/* design/sll_checker.sv */
// sll_checker: port-level assertions for sequential_list_engine_core, plus its bind.
// Depends on sll_pkg.
`default_nettype none

module sll_checker
    import sll_pkg::*;
#(
    parameter  int CAPACITY = 64,
    localparam int PW  = $clog2(CAPACITY + 1),
    localparam int FW  = PW + 1,
    localparam int ODW = ((STAT_W + FW + PW + 7) / 8) * 8
)
(
    input wire            clk,
    input wire            rst_n,
    input wire            m_tvalid,
    input wire            m_tready,
    input wire [ODW-1:0]  m_tdata
);

    logic [STAT_W-1:0] status;
    logic [FW-1:0]     found;
    logic [PW-1:0]     cnt;

    assign status = m_tdata[STAT_W-1:0];
    assign found  = m_tdata[STAT_W+FW-1:STAT_W];
    assign cnt    = m_tdata[STAT_W+FW+PW-1:STAT_W+FW];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && status == ST_FULL |-> cnt == PW'(CAPACITY))
        else $error("full status with list not at capacity");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && status == ST_EMPTY |-> cnt == '0)
        else $error("empty status with elements held");

    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && found != '0 && found != '1 |-> status == ST_OK && found <= FW'(cnt))
        else $error("found position beyond count");

endmodule

bind sequential_list_engine_core sll_checker #(.CAPACITY(CAPACITY)) u_sll_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* sim/sequential_list_engine_core_tb.sv */
// Testbench for sequential_list_engine_core: directed and random list requests,
// checked against a queue-based shadow of the list. Depends on sll_pkg and the core RTL.
`timescale 1ns / 100ps

module sequential_list_engine_core_tb;
    import sll_pkg::*;

    localparam int CAPACITY   = 64;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_LONG  = 300;

    localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 4'd9;
    localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 4'd15;

    localparam logic [31:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_NEG1 = 32'hFFFF_FFFF;
    localparam logic [31:0] VAL_A5   = 32'h5555_5555;
    localparam logic [31:0] VAL_5A   = 32'hAAAA_AAAA;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [7:0]        found;
        logic [6:0]        count;
    } list_result_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [39:0]       s_tdata;
    logic [FUNC_W-1:0] s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [23:0]       m_tdata;

    logic [31:0]  list_shadow[$];
    list_result_t expected_results[$];
    int           mismatches;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_left;
    int           quiet_cycles;

    sequential_list_engine_core #(.CAPACITY(CAPACITY)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic list_result_t apply_list_request(input logic [FUNC_W-1:0] fn,
                                                        input logic [6:0] pos,
                                                        input logic [31:0] val);
        list_result_t r;
        int n;
        r.status = ST_OK;
        r.found  = '0;
        n = list_shadow.size();
        case (fn)
            FN_PUSH_BACK:
                if (n >= CAPACITY) r.status = ST_FULL;
                else list_shadow.push_back(val);
            FN_PUSH_FRONT:
                if (n >= CAPACITY) r.status = ST_FULL;
                else list_shadow.push_front(val);
            FN_POP_BACK:
                if (n == 0) r.status = ST_EMPTY;
                else void'(list_shadow.pop_back());
            FN_POP_FRONT:
                if (n == 0) r.status = ST_EMPTY;
                else void'(list_shadow.pop_front());
            FN_INSERT:
                if (n >= CAPACITY) r.status = ST_FULL;
                else if (pos < 1 || pos > n + 1) r.status = ST_BADPOS;
                else list_shadow.insert(pos - 1, val);
            FN_ERASE:
                if (n == 0) r.status = ST_EMPTY;
                else if (pos < 1 || pos > n) r.status = ST_BADPOS;
                else list_shadow.delete(pos - 1);
            FN_FIND:
            begin
                r.found = 8'hFF;
                for (int k = 0; k < n; k++)
                begin
                    if (list_shadow[k] == val)
                    begin
                        r.found = 8'(k + 1);
                        break;
                    end
                end
            end
            FN_MODIFY:
                if (n == 0) r.status = ST_EMPTY;
                else if (pos < 1 || pos > n) r.status = ST_BADPOS;
                else list_shadow[pos - 1] = val;
            FN_CLEAR:
                list_shadow.delete();
            default: ;
        endcase
        r.count = 7'(list_shadow.size());
        return r;
    endfunction

    task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [6:0] pos,
                                input logic [31:0] val);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {1'b0, val, pos};
        do @(posedge clk); while (!s_tready);
        expected_results.push_back(apply_list_request(fn, pos, val));
    endtask

    function automatic logic [31:0] pick_value(input int hit_pct);
        int r;
        r = $urandom_range(99);
        if (r < hit_pct && list_shadow.size() > 0)
            return list_shadow[$urandom_range(list_shadow.size() - 1)];
        else if (r < hit_pct + 30)
            return $urandom_range(6) - 3;
        else if (r < hit_pct + 36)
            return ($urandom_range(1) != 0) ? VAL_MIN : VAL_MAX;
        return $urandom;
    endfunction

    task automatic send_random(input int grow_pct);
        logic [FUNC_W-1:0] fn;
        logic [6:0]        pos;
        int                n;
        int                r;
        n = list_shadow.size();
        if ($urandom_range(99) < grow_pct)
        begin
            r = $urandom_range(2);
            fn = (r == 0) ? FN_PUSH_BACK : (r == 1) ? FN_PUSH_FRONT : FN_INSERT;
        end
        else
        begin
            r = $urandom_range(99);
            if (r < 15)      fn = FN_POP_BACK;
            else if (r < 30) fn = FN_POP_FRONT;
            else if (r < 50) fn = FN_ERASE;
            else if (r < 73) fn = FN_FIND;
            else if (r < 96) fn = FN_MODIFY;
            else if (r < 98) fn = FN_CLEAR;
            else             fn = FUNC_W'($urandom_range(FN_UNUSED_HI, FN_UNUSED_LO));
        end
        if ($urandom_range(99) < 15)
            pos = 7'($urandom_range(CAPACITY));
        else if (fn == FN_INSERT)
            pos = 7'($urandom_range(n + 1, 1));
        else
            pos = 7'($urandom_range((n > 0) ? n : 1, 1));
        send_request(fn, pos, pick_value((fn == FN_FIND) ? 50 : 8));
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_request(FN_PUSH_BACK,  7'd0,  VAL_MIN);
        send_request(FN_PUSH_FRONT, 7'd0,  VAL_MAX);
        send_request(FN_INSERT,     7'd3,  32'd0);
        send_request(FN_INSERT,     7'd1,  VAL_NEG1);
        send_request(FN_INSERT,     7'd0,  32'd7);
        send_request(FN_INSERT,     7'd6,  32'd7);
        send_request(FN_FIND,       7'd0,  VAL_MIN);
        send_request(FN_FIND,       7'd64, 32'd5);
        send_request(FN_MODIFY,     7'd4,  VAL_A5);
        send_request(FN_MODIFY,     7'd5,  32'd1);
        send_request(FN_MODIFY,     7'd0,  32'd1);
        send_request(FN_ERASE,      7'd64, 32'd0);
        send_request(FN_ERASE,      7'd2,  32'd0);
        send_request(FN_POP_FRONT,  7'd0,  32'd0);
        send_request(FN_FIND,       7'd64, VAL_5A);
        send_request(FN_POP_BACK,   7'd0,  32'd0);
        send_request(FN_POP_BACK,   7'd0,  32'd0);
        // empty list
        send_request(FN_POP_BACK,   7'd0,  32'd0);
        send_request(FN_POP_FRONT,  7'd0,  32'd0);
        send_request(FN_ERASE,      7'd1,  32'd0);
        send_request(FN_MODIFY,     7'd1,  32'd0);
        send_request(FN_FIND,       7'd1,  32'd0);
        send_request(FN_UNUSED_LO,  7'd1,  VAL_NEG1);
        send_request(FN_UNUSED_HI,  7'd64, VAL_NEG1);
        send_request(FN_INSERT,     7'd1,  VAL_5A);
        send_request(FN_CLEAR,      7'd0,  32'd0);
    endtask

    task automatic test_random(input int n_items, input int send_pct, input int recv_pct);
        int sent;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        // fill up, then hit the full list a few times
        while (list_shadow.size() < CAPACITY)
        begin
            send_random(95);
            sent++;
        end
        repeat (6)
        begin
            send_random(100);
            sent++;
        end
        while (sent < n_items)
        begin
            send_random((sent < n_items * 3 / 4) ? 50 : 20);
            sent++;
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = HOLD_LONG;
        repeat (12) send_random(50);
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        m_tready <= 1'b0;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(150, 0, 0);
        test_random(150, 79, 0);
        test_random(150, 0, 79);
        test_backpressure();
        test_random(150, 18, 18);

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : check_results
        list_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request pending: %h", m_tdata);
                mismatches++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (m_tdata[1:0] !== exp_r.status)
                begin
                    $error("status: expected %0d, got %0d", exp_r.status, m_tdata[1:0]);
                    mismatches++;
                end
                if (m_tdata[9:2] !== exp_r.found)
                begin
                    $error("found_position: expected %0d, got %0d",
                           $signed(exp_r.found), $signed(m_tdata[9:2]));
                    mismatches++;
                end
                if (m_tdata[16:10] !== exp_r.count)
                begin
                    $error("item_count: expected %0d, got %0d", exp_r.count, m_tdata[16:10]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial quiet_cycles = 0;

endmodule

/* sequential_list_engine_core.f */
design/sll_pkg.sv
design/sll_cell.sv
design/sequential_list_engine_core.sv
design/sll_checker.sv
sim/sequential_list_engine_core_tb.sv
